FILE: hdl/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared sizes, codes and the divider request bundle for the hodgepodge engine.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = 1 + ROW_W + COL_W;
  localparam int CELL_W   = 8;
  localparam int DVD_W    = 11;   // eight neighbors of up to 255
  localparam int DVS_W    = 4;    // divisors are 1..15
  localparam int CNT_W    = 4;    // neighbor counts are 0..8

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [2:0] REG_INC    = 3'd0;
  localparam logic [2:0] REG_K1     = 3'd1;
  localparam logic [2:0] REG_K2     = 3'd2;
  localparam logic [2:0] REG_MAX    = 3'd3;
  localparam logic [2:0] REG_ROWS   = 3'd4;
  localparam logic [2:0] REG_COLS   = 3'd5;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

endpackage

FILE: hdl/hpa_div.sv
// ----------------------------------------------------------------------------
// hpa_div
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
// ----------------------------------------------------------------------------
module hpa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hpa_pkg::div_req_t          req,
  output logic                       busy,
  output logic                       done,
  output logic [hpa_pkg::DVD_W-1:0]  quot
);

  logic [hpa_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [hpa_pkg::DVS_W-1:0] dvs_r;
  logic [hpa_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [3:0]                cnt_r;
  logic                      busy_r, done_r;
  logic [hpa_pkg::DVS_W:0]   trial;
  logic                      qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[hpa_pkg::DVD_W-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? hpa_pkg::DVS_W'(trial - {1'b0, dvs_r}) : trial[hpa_pkg::DVS_W-1:0];
    dvd_nxt = {dvd_r[hpa_pkg::DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(hpa_pkg::DVD_W - 1);
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dvd_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (req.divisor != '0)) else $error("divide by zero");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a run");

endmodule

FILE: hdl/hodgepodge_automaton_engine_top.sv
// ----------------------------------------------------------------------------
// hodgepodge_automaton_engine_top
// Double-buffered toroidal hodgepodge grid with host cell access and step.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------
//   in      | in  | in_valid/in_ready  | opcode, row, col, value
//   out     | out | out_valid/out_ready| read_value, status
//   cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// Write and unused opcodes go straight to the result state; a read first
// waits for its cell. A step sweeps all 64x128 cells through the single read
// port: a cell outside the region is copied; an in-region cell is read with
// its eight neighbors, then written at once if ill or infected with no infected
// neighbor, or after one (infected) or two (healthy) bit-serial divisions.
// Reset clears control and registers; cell memory is not cleared.
// A result waiting on out_ready holds the engine in its result state only.
// ----------------------------------------------------------------------------
module hodgepodge_automaton_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_row,
  input  logic [6:0]  in_col,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_value,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int RW = hpa_pkg::ROW_W;
  localparam int CW = hpa_pkg::COL_W;
  localparam int AW = hpa_pkg::ADDR_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDW, ST_RESP, ST_CELL, ST_GATHER, ST_LAST,
    ST_EVAL, ST_DIV1, ST_DIV2, ST_DIV3, ST_COPY, ST_WRITE
  } state_t;

  state_t state_r;

  // configuration
  logic [7:0] inc_r, max_r, cols_r;
  logic [3:0] k1_r, k2_r;
  logic [6:0] rows_r;

  logic       act_r;
  logic [RW-1:0] r_r;
  logic [CW-1:0] c_r;
  logic [3:0] k_r;
  logic       pend_v_r;
  logic [3:0] pend_k_r;
  logic [7:0] cur_r;
  logic [10:0] sum_r;
  logic [3:0] a_r, b_r;
  logic [10:0] q1_r;
  logic [7:0] res_r;
  logic       out_valid_r;
  logic [7:0] out_val_r, resp_val_r;
  logic       out_st_r, resp_st_r;

  // memory
  logic [7:0]    mem [2*hpa_pkg::MAX_ROWS*hpa_pkg::MAX_COLS];
  logic [7:0]    mem_q;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_we;

  hpa_pkg::div_req_t div_req;
  logic              div_busy, div_done;
  logic [10:0]       div_quot;

  logic [6:0] r_eff;
  logic [7:0] c_eff;
  logic [RW-1:0] rm, rp, nr;
  logic [CW-1:0] cm, cp, nc;
  logic [6:0] rp7;
  logic [7:0] cp8;
  logic       in_region, host_oob, accept, last_cell;
  logic [3:0] k1_eff, k2_eff;
  logic [11:0] heal_sum, inf_sum;

  always_comb begin
    r_eff = (rows_r > 7'(hpa_pkg::MAX_ROWS)) ? 7'(hpa_pkg::MAX_ROWS) : rows_r;
    c_eff = (cols_r > 8'(hpa_pkg::MAX_COLS)) ? 8'(hpa_pkg::MAX_COLS) : cols_r;
    k1_eff = (k1_r == 4'd0) ? 4'd1 : k1_r;
    k2_eff = (k2_r == 4'd0) ? 4'd1 : k2_r;

    rm  = (r_r == '0) ? RW'(r_eff - 7'd1) : r_r - RW'(1);
    rp7 = {1'b0, r_r} + 7'd1;
    rp  = (rp7 >= r_eff) ? '0 : rp7[RW-1:0];
    cm  = (c_r == '0) ? CW'(c_eff - 8'd1) : c_r - CW'(1);
    cp8 = {1'b0, c_r} + 8'd1;
    cp  = (cp8 >= c_eff) ? '0 : cp8[CW-1:0];

    unique case (k_r)
      4'd1, 4'd2, 4'd3: nr = rm;
      4'd6, 4'd7, 4'd8: nr = rp;
      default:          nr = r_r;
    endcase
    unique case (k_r)
      4'd1, 4'd4, 4'd6: nc = cm;
      4'd3, 4'd5, 4'd8: nc = cp;
      default:          nc = c_r;
    endcase

    in_region = ({1'b0, r_r} < r_eff) && ({1'b0, c_r} < c_eff);
    host_oob  = ({1'b0, in_row} >= r_eff) || ({1'b0, in_col} >= c_eff);
    last_cell = (r_r == RW'(hpa_pkg::MAX_ROWS - 1)) && (c_r == CW'(hpa_pkg::MAX_COLS - 1));

    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;

    heal_sum = {1'b0, q1_r} + {1'b0, div_quot};
    inf_sum  = {1'b0, div_quot} + {4'd0, inc_r};
  end

  // memory port selection
  always_comb begin
    mem_raddr = {act_r, r_r, c_r};
    mem_waddr = {~act_r, r_r, c_r};
    mem_wdata = res_r;
    mem_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = {act_r, in_row, in_col};
        mem_waddr = {act_r, in_row, in_col};
        mem_wdata = in_value;
        mem_we    = accept && (in_opcode == hpa_pkg::OP_WRITE) && !host_oob;
      end
      ST_GATHER: mem_raddr = {act_r, nr, nc};
      ST_COPY: begin
        mem_wdata = mem_q;
        mem_we    = 1'b1;
      end
      ST_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = a_r;
    unique case (state_r)
      ST_EVAL: begin
        if (cur_r == 8'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = {7'd0, a_r};
          div_req.divisor  = k1_eff;
        end else if (cur_r != max_r && a_r != 4'd0) begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV1: begin
        div_req.start    = div_done;
        div_req.dividend = {7'd0, b_r};
        div_req.divisor  = k2_eff;
      end
      default: ;
    endcase
  end

  hpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      inc_r       <= 8'd13;
      k1_r        <= 4'd2;
      k2_r        <= 4'd3;
      max_r       <= 8'd255;
      rows_r      <= 7'd50;
      cols_r      <= 8'd80;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hpa_pkg::REG_INC:  inc_r  <= cfg_data;
          hpa_pkg::REG_K1:   k1_r   <= cfg_data[3:0];
          hpa_pkg::REG_K2:   k2_r   <= cfg_data[3:0];
          hpa_pkg::REG_MAX:  max_r  <= cfg_data;
          hpa_pkg::REG_ROWS: rows_r <= cfg_data[6:0];
          hpa_pkg::REG_COLS: cols_r <= cfg_data;
          default: ;
        endcase
      end

      // the result state reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_RESP) out_valid_r <= 1'b0;

      // gathered beat from previous cycle
      if (pend_v_r) begin
        if (pend_k_r == 4'd0) begin
          cur_r <= mem_q;
        end else begin
          sum_r <= sum_r + {3'd0, mem_q};
          if (mem_q == max_r)       b_r <= b_r + 4'd1;
          else if (mem_q != 8'd0)   a_r <= a_r + 4'd1;
        end
      end
      pend_v_r <= (state_r == ST_GATHER);
      pend_k_r <= k_r;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            resp_val_r <= 8'd0;
            r_r        <= '0;
            c_r        <= '0;
            if (in_opcode == hpa_pkg::OP_WRITE || in_opcode == hpa_pkg::OP_READ) begin
              resp_st_r <= host_oob;
              state_r   <= (in_opcode == hpa_pkg::OP_READ && !host_oob) ? ST_RDW : ST_RESP;
            end else if (in_opcode == hpa_pkg::OP_STEP) begin
              resp_st_r <= 1'b0;
              state_r   <= ST_CELL;
            end else begin
              resp_st_r <= 1'b0;
              state_r   <= ST_RESP;
            end
          end
        end
        ST_RDW: begin
          resp_val_r <= mem_q;
          state_r    <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= resp_val_r;
            out_st_r    <= resp_st_r;
            state_r     <= ST_IDLE;
          end
        end
        ST_CELL: begin
          sum_r <= '0;
          a_r   <= '0;
          b_r   <= '0;
          k_r   <= '0;
          state_r <= in_region ? ST_GATHER : ST_COPY;
        end
        ST_GATHER: begin
          k_r <= k_r + 4'd1;
          if (k_r == 4'd8) state_r <= ST_LAST;
        end
        ST_LAST: state_r <= ST_EVAL;
        ST_EVAL: begin
          if (cur_r == max_r) begin
            res_r   <= 8'd0;
            state_r <= ST_WRITE;
          end else if (cur_r == 8'd0) begin
            state_r <= ST_DIV1;
          end else if (a_r == 4'd0) begin
            res_r   <= cur_r;
            state_r <= ST_WRITE;
          end else begin
            state_r <= ST_DIV3;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            q1_r    <= div_quot;
            state_r <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            res_r   <= (heal_sum > {4'd0, max_r}) ? max_r : heal_sum[7:0];
            state_r <= ST_WRITE;
          end
        end
        ST_DIV3: begin
          if (div_done) begin
            res_r   <= (inf_sum > {4'd0, max_r}) ? max_r : inf_sum[7:0];
            state_r <= ST_WRITE;
          end
        end
        ST_COPY, ST_WRITE: begin
          if (last_cell) begin
            act_r   <= ~act_r;
            state_r <= ST_RESP;
          end else begin
            state_r <= ST_CELL;
            if (c_r == CW'(hpa_pkg::MAX_COLS - 1)) begin
              c_r <= '0;
              r_r <= r_r + RW'(1);
            end else begin
              c_r <= c_r + CW'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_status     = out_st_r;

  a_step_dst: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != ST_IDLE) |-> (mem_waddr[AW-1] != act_r))
    else $error("step wrote into the live buffer");
  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r != $past(act_r)) |-> ($past(state_r) == ST_COPY || $past(state_r) == ST_WRITE))
    else $error("buffer swap outside a step");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> ({1'b0, a_r} + {1'b0, b_r} <= 5'd8))
    else $error("neighbor counts exceed eight");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV2 || state_r == ST_DIV3) && !div_done |-> div_busy || $past(div_req.start))
    else $error("waiting on idle divider");

endmodule

FILE: verif/tb_hodgepodge_automaton_engine_top.sv
// ----------------------------------------------------------------------------
// tb_hodgepodge_automaton_engine_top
// Self-checking bench for the hodgepodge grid engine. A scoreboard keeps its
// own copy of both cell buffers and the registers. It predicts every
// write/read/step beat and checks the results in order. Register settings
// change between phases, and both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_hodgepodge_automaton_engine_top;

  localparam int PLANE = hpa_pkg::MAX_ROWS * hpa_pkg::MAX_COLS;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode

  class hpa_scoreboard;
    logic [7:0]  grid [2][PLANE];
    bit          known [2][PLANE];   // cell has a defined value
    bit          act;
    int unsigned g_inc, k1, k2, max_st, rows, cols;
    logic [8:0]  due_q[$];           // {status, read_value}
    int          errors, checked, steps, reads, writes;

    function new();
      act = 0;
      g_inc = 13; k1 = 2; k2 = 3; max_st = 255; rows = 50; cols = 80;
      foreach (grid[b, i]) begin
        grid[b][i] = '0;
        known[b][i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] d);
      case (idx)
        hpa_pkg::REG_INC:  g_inc  = 32'(d);
        hpa_pkg::REG_K1:   k1     = 32'(d[3:0]);
        hpa_pkg::REG_K2:   k2     = 32'(d[3:0]);
        hpa_pkg::REG_MAX:  max_st = 32'(d);
        hpa_pkg::REG_ROWS: rows   = 32'(d[6:0]);
        hpa_pkg::REG_COLS: cols   = 32'(d);
        default: ;
      endcase
    endfunction

    function int unsigned num_rows();
      return (rows > hpa_pkg::MAX_ROWS) ? hpa_pkg::MAX_ROWS : rows;
    endfunction

    function int unsigned num_cols();
      return (cols > hpa_pkg::MAX_COLS) ? hpa_pkg::MAX_COLS : cols;
    endfunction

    function logic [7:0] evolve(bit b, int unsigned r, int unsigned c);
      int unsigned rr[3], cc[3];
      int unsigned nr, nc, a, ill, sum, cur, v, res, d1, d2;
      nr = num_rows(); nc = num_cols();
      a = 0; ill = 0; sum = 0;
      d1 = (k1 == 0) ? 1 : k1;
      d2 = (k2 == 0) ? 1 : k2;
      rr[0] = (r == 0) ? nr - 1 : r - 1;
      rr[1] = r;
      rr[2] = (r + 1 >= nr) ? 0 : r + 1;
      cc[0] = (c == 0) ? nc - 1 : c - 1;
      cc[1] = c;
      cc[2] = (c + 1 >= nc) ? 0 : c + 1;
      cur = 32'(grid[b][r * hpa_pkg::MAX_COLS + c]);
      if (cur == max_st) return 8'd0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (i == 1 && j == 1) continue;
          v = 32'(grid[b][rr[i] * hpa_pkg::MAX_COLS + cc[j]]);
          sum += v;
          if (v == max_st) ill++;
          else if (v != 0) a++;
        end
      if (cur == 0) res = a / d1 + ill / d2;
      else if (a == 0) return cur[7:0];
      else res = sum / a + g_inc;
      if (res > max_st) res = max_st;
      return res[7:0];
    endfunction

    function bit in_region(int unsigned r, int unsigned c);
      return (r < num_rows()) && (c < num_cols());
    endfunction

    function bit region_full();
      for (int r = 0; r < num_rows(); r++)
        for (int c = 0; c < num_cols(); c++)
          if (!known[act][r * hpa_pkg::MAX_COLS + c]) return 0;
      return 1;
    endfunction

    function void note(logic [1:0] op, logic [5:0] r, logic [6:0] c, logic [7:0] val);
      int unsigned idx;
      logic [7:0] rv;
      logic st;
      bit dst;
      idx = 32'(r) * hpa_pkg::MAX_COLS + 32'(c);
      rv = '0; st = 0;
      if (op == hpa_pkg::OP_WRITE || op == hpa_pkg::OP_READ) begin
        if (!in_region(32'(r), 32'(c))) st = 1;
        else if (op == hpa_pkg::OP_WRITE) begin
          grid[act][idx] = val;
          known[act][idx] = 1;
          writes++;
        end else begin
          rv = grid[act][idx];
          reads++;
        end
      end else if (op == hpa_pkg::OP_STEP) begin
        dst = ~act;
        for (int rr = 0; rr < hpa_pkg::MAX_ROWS; rr++)
          for (int cc = 0; cc < hpa_pkg::MAX_COLS; cc++) begin
            idx = rr * hpa_pkg::MAX_COLS + cc;
            if (in_region(rr, cc)) begin
              grid[dst][idx] = evolve(act, rr, cc);
              known[dst][idx] = 1;
            end else begin
              grid[dst][idx] = grid[act][idx];
              known[dst][idx] = known[act][idx];
            end
          end
        act = dst;
        steps++;
      end
      due_q.push_back({st, rv});
    endfunction

    function void check(logic [7:0] rv, logic st);
      logic [8:0] exp_res;
      checked++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result beat value=%0d status=%0d", rv, st);
        return;
      end
      exp_res = due_q.pop_front();
      if (exp_res[7:0] !== rv || exp_res[8] !== st) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d exp value=%0d status=%0d got value=%0d status=%0d",
                   checked, exp_res[7:0], exp_res[8], rv, st);
      end
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_ready;
  logic [1:0] in_opcode;
  logic [5:0] in_row;
  logic [6:0] in_col;
  logic [7:0] in_value;
  logic       out_valid, out_ready;
  logic [7:0] out_read_value;
  logic       out_status;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  hpa_scoreboard sb;
  int  cycles;
  bit  long_hold;

  hodgepodge_automaton_engine_top dut (.*);

  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("FAIL hodgepodge_automaton_engine_top");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check(out_read_value, out_status);

  // result side: random stalls, one long hold-off on request
  initial begin
    int r;
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end else begin
        r = $urandom_range(99);
        if (r < 60) out_ready <= 1;
        else if (r < 95) out_ready <= 0;
        else begin
          out_ready <= 0;
          repeat ($urandom_range(40, 10)) @(posedge clk);
        end
      end
    end
  end

  task automatic send(logic [1:0] op, int unsigned r, int unsigned c, logic [7:0] val);
    int g, n;
    g = $urandom_range(99);
    n = (g < 50) ? 0 : (g < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid  <= 1;
    in_opcode <= op;
    in_row    <= r[5:0];
    in_col    <= c[6:0];
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    sb.note(op, r[5:0], c[6:0], val);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(int unsigned inc, int unsigned d1, int unsigned d2,
                           int unsigned mx, int unsigned nr, int unsigned nc);
    logic [7:0] vals[6];
    vals = '{inc[7:0], d1[7:0], d2[7:0], mx[7:0], nr[7:0], nc[7:0]};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(i[2:0], vals[i]);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] cell_value();
    int r;
    r = $urandom_range(9);
    if (sb.max_st < 2 || r == 4) return 8'($urandom_range(255));
    if (r < 2) return 8'd0;
    if (r < 4) return sb.max_st[7:0];
    return 8'($urandom_range(sb.max_st - 1, 1));
  endfunction

  task automatic fill_region();
    for (int r = 0; r < sb.num_rows(); r++)
      for (int c = 0; c < sb.num_cols(); c++)
        send(hpa_pkg::OP_WRITE, r, c, cell_value());
  endtask

  // mostly well-formed traffic: steps only once the region is fully defined
  task automatic random_traffic(int n);
    int p;
    int unsigned r, c;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if ($urandom_range(99) < 85 && sb.num_rows() > 0 && sb.num_cols() > 0) begin
        r = $urandom_range(sb.num_rows() - 1);
        c = $urandom_range(sb.num_cols() - 1);
      end else begin
        r = $urandom_range(63);
        c = $urandom_range(127);
      end
      if (p < 20 && sb.region_full())
        send(hpa_pkg::OP_STEP, $urandom_range(63), $urandom_range(127),
             8'($urandom_range(255)));
      else if (p < 25)
        send(OP_NONE, r, c, 8'($urandom_range(255)));
      else if (p < 60 &&
               (!sb.in_region(r, c) || sb.known[sb.act][r * hpa_pkg::MAX_COLS + c]))
        send(hpa_pkg::OP_READ, r, c, 8'($urandom_range(255)));
      else
        send(hpa_pkg::OP_WRITE, r, c, cell_value());
    end
  endtask

  initial begin
    sb = new();
    rst_n     <= 0;
    in_valid  <= 0;
    in_opcode <= hpa_pkg::OP_WRITE;
    in_row    <= '0;
    in_col    <= '0;
    in_value  <= '0;
    cfg_we    <= 0;
    cfg_index <= '0;
    cfg_data  <= '0;
    long_hold = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: corners, out-of-range, unused opcode, at reset settings
    send(hpa_pkg::OP_WRITE, 0, 0, 8'd0);
    send(hpa_pkg::OP_WRITE, 49, 79, 8'd255);
    send(hpa_pkg::OP_WRITE, 63, 127, 8'd77);
    send(hpa_pkg::OP_WRITE, 0, 79, 8'd128);
    send(hpa_pkg::OP_READ, 0, 0, 8'd255);
    send(hpa_pkg::OP_READ, 49, 79, 8'd0);
    send(hpa_pkg::OP_READ, 63, 127, 8'd0);
    send(hpa_pkg::OP_READ, 50, 0, 8'd0);
    send(hpa_pkg::OP_READ, 0, 80, 8'd0);
    send(OP_NONE, 63, 127, 8'd255);
    send(hpa_pkg::OP_READ, 0, 79, 8'd0);

    // receiver holds off while the sender keeps offering beats
    long_hold = 1;
    for (int i = 0; i < 6; i++) send(hpa_pkg::OP_READ, 0, 0, 8'd0);
    drain();

    // full store: saturated region size, corners only
    configure(13, 2, 3, 255, 127, 255);
    send(hpa_pkg::OP_WRITE, 63, 127, 8'd200);
    send(hpa_pkg::OP_READ, 63, 127, 8'd0);
    send(hpa_pkg::OP_WRITE, 0, 127, 8'd1);
    send(hpa_pkg::OP_READ, 0, 127, 8'd0);

    configure(0, 1, 1, 2, 3, 3);
    fill_region();
    send(hpa_pkg::OP_STEP, 0, 0, 8'd0);
    random_traffic(6);

    configure(255, 8, 8, 255, 4, 5);
    fill_region();
    random_traffic(6);

    // zero divisors, one column, two rows
    configure(7, 0, 0, 9, 2, 1);
    fill_region();
    random_traffic(5);

    // empty region: steps only swap buffers
    configure(20, 3, 15, 100, 0, 0);
    send(hpa_pkg::OP_WRITE, 0, 0, 8'd5);
    send(hpa_pkg::OP_STEP, 0, 0, 8'd0);
    send(hpa_pkg::OP_READ, 0, 0, 8'd0);
    send(hpa_pkg::OP_STEP, 0, 0, 8'd0);

    configure(100, 2, 3, 50, 3, 4);
    fill_region();
    random_traffic(6);

    configure(13, 2, 3, 255, 1, 2);
    fill_region();
    random_traffic(4);

    configure(13, 2, 3, 255, 4, 3);
    fill_region();
    random_traffic(6);

    drain();
    $display("Covered %0d writes, %0d in-region reads and %0d generation steps",
             sb.writes, sb.reads, sb.steps);
    $display("across nine register settings; %0d result beats checked", sb.checked);
    if (sb.errors == 0 && sb.due_q.size() == 0)
      $display("PASS hodgepodge_automaton_engine_top");
    else begin
      $display("ERROR: %0d mismatches, %0d results missing", sb.errors, sb.due_q.size());
      $display("FAIL hodgepodge_automaton_engine_top");
    end
    $finish;
  end

endmodule
